/* rtl/pdd_pkg.sv */
package pdd_pkg;

    localparam int MAX_LEVELS_DEF  = 4;
    localparam int MAX_ANCHORS_DEF = 8;

    // wide enough for any count compare at the default parameter values
    localparam int CMP_W = 8;
    localparam int SH_W  = 6;

    typedef enum logic [2:0] {
        CFG_NUM_LEVELS      = 3'd0,
        CFG_NUM_ANCHORS     = 3'd1,
        CFG_ANCHOR_STEP     = 3'd2,
        CFG_SCORE_THRESHOLD = 3'd3,
        CFG_IMAGE_WIDTH     = 3'd4,
        CFG_IMAGE_HEIGHT    = 3'd5
    } t_cfg_idx;

    localparam logic [2:0]  RST_NUM_LEVELS      = 3'd3;
    localparam logic [3:0]  RST_NUM_ANCHORS     = 4'd1;
    localparam logic [16:0] RST_ANCHOR_STEP     = 17'd65536;
    localparam logic [30:0] RST_SCORE_THRESHOLD = 31'd3355443;
    localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd416;
    localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd416;

    typedef struct packed {
        logic signed [15:0] objectness;
        logic signed [15:0] class_prob;
        logic signed [15:0] pred_x;
        logic signed [15:0] pred_y;
        logic signed [15:0] pred_h;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [11:0]        pred_index;
        logic signed [31:0] score;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] box_width;
        logic signed [31:0] box_height;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [30:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [2:0]  num_levels;
        logic [3:0]  num_anchors;
        logic [16:0] anchor_step;
        logic [30:0] score_threshold;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic wide;
        logic pack;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_WIDE,
        ST_PACK
    } t_state;

    function automatic int pdd_max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

/* rtl/pdd_if.sv */
interface pdd_in_if;
    import pdd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pdd_out_if;
    import pdd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pdd_cfg_if;
    import pdd_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/pyramid_detection_decoder.sv */
// An accepted input beat passes the multiply, add and wide states and then the pack state,
// which waits while the result register still holds an untaken beat. The item steps through
// three multiply/add stages and a round-and-saturate stage, one item in flight at a time.
// The result register lets the next input beat be taken while a result waits.
// Reset: synchronous, active low; clears the pyramid counters and the controller, and
// returns the configuration registers to their defaults.
module pyramid_detection_decoder
    import pdd_pkg::*;
#(
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
    parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdd_in_if.sink        i_in,
    pdd_out_if.source     o_out,
    pdd_cfg_if.sink       i_cfg
);

    t_cfg      w_cfg;
    t_dp_cmd   w_cmd;
    t_out_item w_result;
    logic      w_in_ready;
    logic      w_out_valid;
    logic      w_cfg_ready;

    pdd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr       (i_cfg.data),
        .o_wr_ready (w_cfg_ready),
        .o_cfg      (w_cfg)
    );

    pdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    pdd_datapath #(
        .MAX_LEVELS  (MAX_LEVELS),
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (w_cfg),
        .i_item   (i_in.data),
        .o_result (w_result)
    );

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = w_cfg_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_result;

    // an accepted beat walks the arithmetic steps in order
    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_cmd.mul ##1 w_cmd.add ##1 w_cmd.wide))
        else $error("arithmetic steps out of order after accept");

    // a miss carries an empty box
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.hit) |->
        (o_out.data.center_x == 32'sd0 && o_out.data.center_y == 32'sd0 &&
         o_out.data.box_width == 32'sd0 && o_out.data.box_height == 32'sd0))
        else $error("box fields set on a miss");

    // a hit means the score is above the threshold in force
    a_hit_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.hit) |->
        (33'(o_out.data.score) > $signed({2'b00, w_cfg.score_threshold})))
        else $error("hit flagged with score not above threshold");

    // nothing new is taken while an item is being worked
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in progress");

endmodule

/* rtl/pdd_cfg_regs.sv */
module pdd_cfg_regs
    import pdd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_valid,
    input  t_cfg_wr i_wr,
    output logic    o_wr_ready,
    output t_cfg    o_cfg
);

    t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_levels      <= RST_NUM_LEVELS;
            r_cfg.num_anchors     <= RST_NUM_ANCHORS;
            r_cfg.anchor_step     <= RST_ANCHOR_STEP;
            r_cfg.score_threshold <= RST_SCORE_THRESHOLD;
            r_cfg.image_width     <= RST_IMAGE_WIDTH;
            r_cfg.image_height    <= RST_IMAGE_HEIGHT;
        end else if (i_wr_valid) begin
            case (t_cfg_idx'(i_wr.index))
                CFG_NUM_LEVELS:      r_cfg.num_levels      <= i_wr.value[2:0];
                CFG_NUM_ANCHORS:     r_cfg.num_anchors     <= i_wr.value[3:0];
                CFG_ANCHOR_STEP:     r_cfg.anchor_step     <= i_wr.value[16:0];
                CFG_SCORE_THRESHOLD: r_cfg.score_threshold <= i_wr.value[30:0];
                CFG_IMAGE_WIDTH:     r_cfg.image_width     <= i_wr.value[12:0];
                CFG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_wr.value[12:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/pdd_ctrl.sv */
module pdd_ctrl
    import pdd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_WIDE;
            ST_WIDE: n_state = ST_PACK;
            ST_PACK: if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL:  o_cmd.mul  = 1'b1;
            ST_ADD:  o_cmd.add  = 1'b1;
            ST_WIDE: o_cmd.wide = 1'b1;
            ST_PACK: o_cmd.pack = slot_free;
            default: ;
        endcase
    end

    // the result register frees once its beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.pack) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/pdd_datapath.sv */
module pdd_datapath
    import pdd_pkg::*;
#(
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
    parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int ROW_W = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
    localparam int AC_W  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int PXS_W = 34;
    localparam int ACS_W = AC_W + 17;
    localparam int XQ_W  = pdd_max3(32, 29 + AC_W, 28 + ROW_W) + 3;
    localparam int XP_W  = XQ_W + 14;
    localparam int YQ_W  = 13 + ROW_W;
    localparam int YP_W  = YQ_W + 13;
    localparam int RW    = XP_W + 1;

    localparam logic signed [RW-1:0] SAT_HI = RW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [RW-1:0] SAT_LO = RW'(64'shFFFF_FFFF_8000_0000);

    // round half up, then arithmetic shift
    function automatic logic signed [RW-1:0] round_sh(
        input logic signed [RW-1:0] v,
        input logic [SH_W-1:0]      sh
    );
        logic signed [RW-1:0] bias;
        bias = $signed(RW'(1) << (sh - SH_W'(1)));
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return 32'sh8000_0000;
        end
        return $signed(v[31:0]);
    endfunction

    // running position in the pyramid
    logic [LVL_W-1:0] r_level_cnt, n_level_cnt;
    logic [ROW_W-1:0] r_row_cnt, n_row_cnt;
    logic [ROW_W-1:0] r_col_cnt, n_col_cnt;
    logic [AC_W-1:0]  r_anchor_cnt, n_anchor_cnt;
    logic [11:0]      r_index_cnt, n_index_cnt;

    logic [CMP_W-1:0] nl_c, na_c, rows_c;
    logic [LVL_W-1:0] lvl_c;
    logic             end_a, end_c, end_r, end_l;

    // captured item
    logic signed [15:0] r_obj, r_cls, r_px, r_py, r_ph;
    logic [AC_W-1:0]    r_ac;
    logic [ROW_W-1:0]   r_col, r_row;
    logic [LVL_W-1:0]   r_lvl;
    logic [11:0]        r_idx;
    logic               r_last;

    logic signed [31:0]      r_score;
    logic signed [PXS_W-1:0] r_pxs;
    logic [ACS_W-1:0]        r_acs;
    logic [YQ_W-1:0]         r_yq;
    logic signed [16:0]      r_hq;
    logic [15:0]             r_w5;
    logic [12:0]             yc;

    logic                    r_hit;
    logic signed [XQ_W-1:0]  r_xq;
    logic [YP_W-1:0]         r_yp;
    logic signed [30:0]      r_hp;
    logic signed [33:0]      r_wp;

    logic signed [XP_W-1:0]  r_xp;

    t_out_item        r_out;
    logic [SH_W-1:0]  x_sh, y_sh, w_sh, h_sh;

    always_comb begin
        nl_c = CMP_W'(i_cfg.num_levels);
        if (nl_c < CMP_W'(1)) nl_c = CMP_W'(1);
        if (nl_c > CMP_W'(MAX_LEVELS)) nl_c = CMP_W'(MAX_LEVELS);
        na_c = CMP_W'(i_cfg.num_anchors);
        if (na_c < CMP_W'(1)) na_c = CMP_W'(1);
        if (na_c > CMP_W'(MAX_ANCHORS)) na_c = CMP_W'(MAX_ANCHORS);

        lvl_c = r_level_cnt;
        if (r_level_cnt > LVL_W'(MAX_LEVELS - 1)) lvl_c = LVL_W'(MAX_LEVELS - 1);
        rows_c = CMP_W'(1) << lvl_c;

        end_a = (CMP_W'(r_anchor_cnt) + CMP_W'(1)) >= na_c;
        end_c = (CMP_W'(r_col_cnt) + CMP_W'(1)) >= rows_c;
        end_r = (CMP_W'(r_row_cnt) + CMP_W'(1)) >= rows_c;
        end_l = (CMP_W'(r_level_cnt) + CMP_W'(1)) >= nl_c;
    end

    always_comb begin
        n_anchor_cnt = r_anchor_cnt;
        n_col_cnt    = r_col_cnt;
        n_row_cnt    = r_row_cnt;
        n_level_cnt  = r_level_cnt;
        n_index_cnt  = r_index_cnt + 12'd1;
        if (!end_a) begin
            n_anchor_cnt = r_anchor_cnt + AC_W'(1);
        end else begin
            n_anchor_cnt = '0;
            if (!end_c) begin
                n_col_cnt = r_col_cnt + ROW_W'(1);
            end else begin
                n_col_cnt = '0;
                if (!end_r) begin
                    n_row_cnt = r_row_cnt + ROW_W'(1);
                end else begin
                    n_row_cnt = '0;
                    if (!end_l) begin
                        n_level_cnt = r_level_cnt + LVL_W'(1);
                    end else begin
                        n_level_cnt = '0;
                        n_index_cnt = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_cnt  <= '0;
            r_row_cnt    <= '0;
            r_col_cnt    <= '0;
            r_anchor_cnt <= '0;
            r_index_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_level_cnt  <= n_level_cnt;
            r_row_cnt    <= n_row_cnt;
            r_col_cnt    <= n_col_cnt;
            r_anchor_cnt <= n_anchor_cnt;
            r_index_cnt  <= n_index_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_obj  <= i_item.objectness;
            r_cls  <= i_item.class_prob;
            r_px   <= i_item.pred_x;
            r_py   <= i_item.pred_y;
            r_ph   <= i_item.pred_h;
            r_ac   <= r_anchor_cnt;
            r_col  <= r_col_cnt;
            r_row  <= r_row_cnt;
            r_lvl  <= lvl_c;
            r_idx  <= r_index_cnt;
            r_last <= end_a && end_c && end_r && end_l;
        end
    end

    always_comb begin
        if (r_py < 16'sd0) begin
            yc = 13'd0;
        end else if (r_py > 16'sd4096) begin
            yc = 13'd4096;
        end else begin
            yc = r_py[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_score <= 32'(r_obj) * 32'(r_cls);
            r_pxs   <= PXS_W'(r_px) * PXS_W'($signed({1'b0, i_cfg.anchor_step}));
            r_acs   <= ACS_W'(r_ac) * ACS_W'(i_cfg.anchor_step);
            r_yq    <= YQ_W'(yc) + YQ_W'({r_row, 12'b0});
            r_hq    <= 17'(r_ph) + 17'sd4096;
            r_w5    <= 16'(i_cfg.image_width) * 16'd5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_hit <= 33'(r_score) > $signed({2'b00, i_cfg.score_threshold});
            r_xq  <= XQ_W'(r_pxs) + XQ_W'($signed({1'b0, r_acs, 12'b0}))
                   + XQ_W'($signed({1'b0, r_col, 28'b0}));
            r_yp  <= YP_W'(r_yq) * YP_W'(i_cfg.image_height);
            r_hp  <= 31'(r_hq) * 31'($signed({1'b0, i_cfg.image_height}));
            r_wp  <= 34'(r_hq) * 34'($signed({1'b0, r_w5}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wide) begin
            r_xp <= XP_W'(r_xq) * XP_W'($signed({1'b0, i_cfg.image_width}));
        end
    end

    assign x_sh = SH_W'(20) + SH_W'(r_lvl);
    assign y_sh = SH_W'(4) + SH_W'(r_lvl);
    assign w_sh = SH_W'(9) + SH_W'(r_lvl);
    assign h_sh = SH_W'(5) + SH_W'(r_lvl);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pack) begin
            r_out.hit        <= r_hit;
            r_out.pred_index <= r_idx;
            r_out.score      <= r_score;
            r_out.last       <= r_last;
            if (r_hit) begin
                r_out.center_x   <= sat32(round_sh(RW'(r_xp), x_sh));
                r_out.center_y   <= sat32(round_sh(RW'($signed({1'b0, r_yp})), y_sh));
                r_out.box_width  <= sat32(round_sh(RW'(r_wp), w_sh));
                r_out.box_height <= sat32(round_sh(RW'(r_hp), h_sh));
            end else begin
                r_out.center_x   <= '0;
                r_out.center_y   <= '0;
                r_out.box_width  <= '0;
                r_out.box_height <= '0;
            end
        end
    end

    assign o_result = r_out;

endmodule

/* test/tb_pyramid_detection_decoder.sv */
module tb_pyramid_detection_decoder;
    import pdd_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 10;

    // objectness, class_prob, pred_x, pred_y, pred_h
    localparam int CORNERS [10][5] = '{
        '{0, 0, 0, 0, 0},
        '{4096, 4096, 0, 0, 0},
        '{32767, 32767, 32767, 32767, 32767},
        '{-32768, -32768, -32768, -32768, -32768},
        '{-32768, 32767, 4096, 4096, 4096},
        '{241, 13923, 2048, 2048, 0},
        '{241, 13924, 2048, 2048, 0},
        '{4096, 4096, 4096, -1, -4096},
        '{4096, 4096, -4096, 4097, 4096},
        '{-4096, -4096, 100, 4096, -32768}
    };

    class box_decode_board;
        t_out_item   expected_boxes[$];
        int          errors;
        int          hits;
        int          misses;
        logic [2:0]  levels_reg;
        logic [3:0]  anchors_reg;
        logic [16:0] step_reg;
        logic [30:0] thr_reg;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        int          lvl_pos;
        int          row_pos;
        int          col_pos;
        int          anc_pos;
        logic [11:0] next_index;

        function new();
            levels_reg  = RST_NUM_LEVELS;
            anchors_reg = RST_NUM_ANCHORS;
            step_reg    = RST_ANCHOR_STEP;
            thr_reg     = RST_SCORE_THRESHOLD;
            width_reg   = RST_IMAGE_WIDTH;
            height_reg  = RST_IMAGE_HEIGHT;
            lvl_pos     = 0;
            row_pos     = 0;
            col_pos     = 0;
            anc_pos     = 0;
            next_index  = '0;
            errors      = 0;
            hits        = 0;
            misses      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [30:0] val);
            case (idx)
                CFG_NUM_LEVELS:      levels_reg  = val[2:0];
                CFG_NUM_ANCHORS:     anchors_reg = val[3:0];
                CFG_ANCHOR_STEP:     step_reg    = val[16:0];
                CFG_SCORE_THRESHOLD: thr_reg     = val;
                CFG_IMAGE_WIDTH:     width_reg   = val[12:0];
                CFG_IMAGE_HEIGHT:    height_reg  = val[12:0];
                default: ;
            endcase
        endfunction

        // round to nearest, ties towards plus infinity
        static function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        static function logic [31:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7fff_ffff;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction

        function void note_prediction(t_in_item it);
            t_out_item box;
            int        nl;
            int        na;
            int        lvl;
            int        rows;
            longint    obj;
            longint    cls;
            longint    px;
            longint    py;
            longint    ph;
            longint    score;
            longint    step;
            longint    xq;
            longint    yq;
            longint    hq;
            bit        end_a;
            bit        end_c;
            bit        end_r;
            bit        end_l;

            nl = (levels_reg < 1) ? 1 : ((levels_reg > 4) ? 4 : int'(levels_reg));
            na = (anchors_reg < 1) ? 1 : ((anchors_reg > 8) ? 8 : int'(anchors_reg));
            lvl  = (lvl_pos > 3) ? 3 : lvl_pos;
            rows = 1 << lvl;

            obj = $signed(it.objectness);
            cls = $signed(it.class_prob);
            px  = $signed(it.pred_x);
            py  = $signed(it.pred_y);
            ph  = $signed(it.pred_h);

            score = obj * cls;
            end_a = (anc_pos + 1 >= na);
            end_c = (col_pos + 1 >= rows);
            end_r = (row_pos + 1 >= rows);
            end_l = (lvl_pos + 1 >= nl);

            box            = '0;
            box.hit        = (score > longint'(thr_reg));
            box.pred_index = next_index;
            box.score      = score[31:0];
            box.last       = end_a && end_c && end_r && end_l;

            if (box.hit) begin
                step = longint'(step_reg);
                xq = px * step + longint'(anc_pos) * step * 4096
                   + longint'(col_pos) * (longint'(1) << 28);
                yq = ((py < 0) ? 0 : ((py > 4096) ? 4096 : py)) + longint'(row_pos) * 4096;
                hq = ph + 4096;
                box.center_x   = sat32(round_shift(xq * longint'(width_reg), 20 + lvl));
                box.center_y   = sat32(round_shift(yq * longint'(height_reg), 4 + lvl));
                box.box_width  = sat32(round_shift(hq * 5 * longint'(width_reg), 9 + lvl));
                box.box_height = sat32(round_shift(hq * longint'(height_reg), 5 + lvl));
            end
            expected_boxes.push_back(box);

            // advance the pyramid walk: anchors, then columns, rows, levels
            next_index = next_index + 12'd1;
            if (!end_a) begin
                anc_pos++;
            end else begin
                anc_pos = 0;
                if (!end_c) begin
                    col_pos++;
                end else begin
                    col_pos = 0;
                    if (!end_r) begin
                        row_pos++;
                    end else begin
                        row_pos = 0;
                        if (!end_l) begin
                            lvl_pos++;
                        end else begin
                            lvl_pos    = 0;
                            next_index = '0;
                        end
                    end
                end
            end
        endfunction

        function void check_field(string name, logic [11:0] idx, logic [31:0] e,
                                  logic [31:0] a);
            if (a !== e) begin
                errors++;
                $display("%0t: box %0d field %s expected %0d (%h) actual %0d (%h)",
                         $time, idx, name, $signed(e), e, $signed(a), a);
            end
        endfunction

        function void check_box(t_out_item got);
            t_out_item exp;

            if (expected_boxes.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing pending, expected none actual box %0d",
                         $time, got.pred_index);
                return;
            end
            exp = expected_boxes.pop_front();
            if (exp.hit) hits++;
            else misses++;
            check_field("hit", exp.pred_index, 32'(exp.hit), 32'(got.hit));
            check_field("pred_index", exp.pred_index, 32'(exp.pred_index),
                        32'(got.pred_index));
            check_field("score", exp.pred_index, exp.score, got.score);
            check_field("center_x", exp.pred_index, exp.center_x, got.center_x);
            check_field("center_y", exp.pred_index, exp.center_y, got.center_y);
            check_field("box_width", exp.pred_index, exp.box_width, got.box_width);
            check_field("box_height", exp.pred_index, exp.box_height, got.box_height);
            check_field("last", exp.pred_index, 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pdd_in_if  in_ch();
    pdd_out_if out_ch();
    pdd_cfg_if cfg_ch();

    pyramid_detection_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    box_decode_board board = new();

    int   items_sent;
    int   settings;
    int   cycles;
    bit   calm;
    bit   hold_flip;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_item(int o, int c, int x, int y, int h);
        t_in_item it;
        it.objectness = o[15:0];
        it.class_prob = c[15:0];
        it.pred_x     = x[15:0];
        it.pred_y     = y[15:0];
        it.pred_h     = h[15:0];
        return it;
    endfunction

    // mostly probability-like values, the rest raw bit patterns
    function automatic t_in_item rand_item();
        if ($urandom_range(0, 9) < 7)
            return make_item($urandom_range(0, 4096), $urandom_range(0, 4096),
                             $urandom_range(0, 4096), int'($urandom_range(0, 5120)) - 512,
                             int'($urandom_range(0, 12288)) - 4096);
        return make_item($urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic send_item(input t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_prediction(it);
        items_sent++;
    endtask

    task automatic send_stream(input int n, input bit no_gaps);
        int gap;
        for (int i = 0; i < n; i++) begin
            gap = (no_gaps || calm) ? 0 : pick_gap();
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            send_item(rand_item());
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_beat(input t_cfg_idx idx, input logic [30:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, val);
    endtask

    task automatic apply_config(input logic [2:0] nl, input logic [3:0] na,
                                input logic [16:0] step, input logic [30:0] thr,
                                input logic [12:0] w, input logic [12:0] h);
        write_beat(CFG_NUM_LEVELS, 31'(nl));
        write_beat(CFG_NUM_ANCHORS, 31'(na));
        write_beat(CFG_ANCHOR_STEP, 31'(step));
        write_beat(CFG_SCORE_THRESHOLD, thr);
        write_beat(CFG_IMAGE_WIDTH, 31'(w));
        write_beat(CFG_IMAGE_HEIGHT, 31'(h));
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [2:0] nl, input logic [3:0] na,
                             input logic [16:0] step, input logic [30:0] thr,
                             input logic [12:0] w, input logic [12:0] h,
                             input int n, input bit squeeze);
        drain();
        apply_config(nl, na, step, thr, w, h);
        calm <= ($urandom_range(0, 3) == 0);
        // starve the result side while the input keeps coming
        if (squeeze) hold_flip <= ~hold_flip;
        @(posedge i_clk);
        send_stream(n, squeeze);
    endtask

    // result side: random back-pressure plus the occasional long hold-off
    initial begin
        int gap_left;
        int hold_left;
        bit seen_flip;

        gap_left     = 0;
        hold_left    = 0;
        seen_flip    = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) board.check_box(out_ch.data);
            if (hold_flip != seen_flip) begin
                seen_flip = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm) gap_left = pick_gap();
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results pending", cycles,
                 board.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [2:0]  nl;
        logic [3:0]  na;
        logic [16:0] step;
        logic [30:0] thr;
        logic [12:0] w;
        logic [12:0] h;
        int          nl_eff;
        int          na_eff;
        int          walk_len;
        int          n;
        int          target;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        calm         = 1'b1;
        hold_flip    = 1'b0;
        items_sent   = 0;
        settings     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner values at the power-up settings, running past the pyramid end
        for (int k = 0; k < 10; k++)
            send_item(make_item(CORNERS[k][0], CORNERS[k][1], CORNERS[k][2],
                                CORNERS[k][3], CORNERS[k][4]));
        for (int k = 10; k < 24; k++) send_item(rand_item());
        in_ch.valid <= 1'b0;

        run_phase(3'd1, 4'd1, 17'd65536, 31'd0, 13'd1, 13'd1, 30, 1'b0);
        run_phase(3'd4, 4'd8, 17'd8192, 31'd3355443, 13'd4096, 13'd4096, 100, 1'b1);
        run_phase(3'd0, 4'd0, 17'd0, 31'h7fff_ffff, 13'd8191, 13'd0, 40, 1'b0);
        run_phase(3'd7, 4'd15, 17'd131071, 31'd0, 13'd0, 13'd8191, 60, 1'b0);
        run_phase(3'd2, 4'd3, 17'd21845, 31'd1 << 20, 13'd640, 13'd480, 50, 1'b0);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            nl = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(1, 4));
            na = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 8));
            nl_eff = (nl < 1) ? 1 : ((nl > 4) ? 4 : int'(nl));
            na_eff = (na < 1) ? 1 : ((na > 8) ? 8 : int'(na));
            step = 17'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                    : 65536 / na_eff);
            case ($urandom_range(0, 9))
                0:       thr = '0;
                1:       thr = 31'($urandom);
                default: thr = 31'($urandom_range(0, 1 << 24));
            endcase
            w = 13'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 4096));
            h = 13'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 4096));
            walk_len = 0;
            for (int l = 0; l < nl_eff; l++) walk_len += (1 << (2 * l)) * na_eff;
            // a whole pyramid's worth of items where short enough, else a random count of 1 to 120
            n = ($urandom_range(0, 1) && walk_len <= 200) ? walk_len : $urandom_range(1, 120);
            run_phase(nl, na, step, thr, w, h, n, $urandom_range(0, 7) == 0);
        end

        drain();
        $display("Decoded %0d prediction groups under %0d register settings", items_sent,
                 settings);
        $display("%0d boxes above threshold, %0d below, %0d mismatches", board.hits,
                 board.misses, board.errors);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* pyramid_detection_decoder.f */
rtl/pdd_pkg.sv
rtl/pdd_if.sv
rtl/pdd_cfg_regs.sv
rtl/pdd_ctrl.sv
rtl/pdd_datapath.sv
rtl/pyramid_detection_decoder.sv
test/tb_pyramid_detection_decoder.sv
